>>> hdl/ptrt_pkg.sv
`default_nettype none
package ptrt_pkg;

    localparam int MAX_TASKS_DEF = 8;

    localparam int FUNC_W  = 2;
    localparam int ID_W    = 8;
    localparam int PER_W   = 8;
    localparam int CNT_W   = 8;
    localparam int STATE_W = 2;
    localparam int SLOT_W  = 3;
    localparam int STS_W   = 2;
    localparam int TC_W    = 4;
    localparam int CFG_W   = 8;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [CFG_W-1:0] MIN_PERIOD_RST = 8'd1;
    localparam logic [CFG_W-1:0] MAX_PERIOD_RST = 8'd255;
    localparam logic [CFG_W-1:0] PRESCALE_RST   = 8'd50;

    localparam logic [1:0] REG_MIN_PERIOD = 2'd0;
    localparam logic [1:0] REG_MAX_PERIOD = 2'd1;
    localparam logic [1:0] REG_PRESCALE   = 2'd2;

    localparam logic [STATE_W-1:0] ST_READY     = 2'd0;
    localparam logic [STATE_W-1:0] ST_BLOCKED   = 2'd1;
    localparam logic [STATE_W-1:0] ST_SUSPENDED = 2'd2;
    localparam logic [STATE_W-1:0] ST_INVALID   = 2'd3;

    localparam logic [STS_W-1:0] STS_OK       = 2'd0;
    localparam logic [STS_W-1:0] STS_NO_SLOT  = 2'd1;
    localparam logic [STS_W-1:0] STS_BAD_PER  = 2'd2;
    localparam logic [STS_W-1:0] STS_FULL     = 2'd3;

    typedef enum logic [1:0] {
        F_CREATE   = 2'd0,
        F_DELETE   = 2'd1,
        F_TICK     = 2'd2,
        F_DISPATCH = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        C_HOLD,
        C_LOAD,
        C_SHIFT,
        C_SHIFT_BLOCK,
        C_TICK
    } t_cell_op;

    typedef enum logic {
        S_IDLE,
        S_DISP
    } t_fsm;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PER_W-1:0]   period;
        logic [CNT_W-1:0]   count;
        logic [STATE_W-1:0] state;
    } t_entry;

endpackage
`default_nettype wire

>>> hdl/ptrt_req_if.sv
`default_nettype none
interface ptrt_req_if;
    import ptrt_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [ID_W-1:0]     task_id;
    logic [PER_W-1:0]    period;
    logic [STATE_W-1:0]  initial_state;
    logic [SLOT_W-1:0]   slot_index;

    modport source (output valid, func, task_id, period, initial_state, slot_index,
                    input ready);
    modport sink   (input valid, func, task_id, period, initial_state, slot_index,
                    output ready);
endinterface
`default_nettype wire

>>> hdl/ptrt_rsp_if.sv
`default_nettype none
interface ptrt_rsp_if;
    import ptrt_pkg::*;

    logic              valid;
    logic              ready;
    logic [STS_W-1:0]  status;
    logic              dispatch_valid;
    logic [ID_W-1:0]   dispatched_id;
    logic [TC_W-1:0]   task_count;
    logic              last;

    modport source (output valid, status, dispatch_valid, dispatched_id, task_count, last,
                    input ready);
    modport sink   (input valid, status, dispatch_valid, dispatched_id, task_count, last,
                    output ready);
endinterface
`default_nettype wire

>>> hdl/ptrt_cell.sv
`default_nettype none
module ptrt_cell (
    input  wire logic              i_clk,
    input  wire ptrt_pkg::t_cell_op i_op,
    input  wire ptrt_pkg::t_entry  i_load,
    input  wire ptrt_pkg::t_entry  i_next,
    output ptrt_pkg::t_entry       o_entry
);
    import ptrt_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_op)
            C_HOLD: begin
                n_entry = r_entry;
            end
            C_LOAD: begin
                n_entry = i_load;
            end
            C_SHIFT: begin
                n_entry = i_next;
            end
            C_SHIFT_BLOCK: begin
                n_entry       = i_next;
                n_entry.state = ST_BLOCKED;
            end
            C_TICK: begin
                if (r_entry.state != ST_SUSPENDED) begin
                    if (r_entry.count >= r_entry.period) begin
                        n_entry.count = CNT_W'(1);
                        n_entry.state = ST_READY;
                    end else begin
                        n_entry.count = r_entry.count + CNT_W'(1);
                    end
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire

>>> hdl/periodic_task_release_table.sv
`default_nettype none
// Periodic task release table. Entries live in a ring of MAX_TASKS cells.
// Create, delete and raw tick requests each return one beat.
// Dispatch rotates the ring one cell per cycle through all MAX_TASKS cells,
// checking the cell at the head, except while the result sink holds off a
// pending beat. Each ready task gives one beat, or one empty beat when none
// is ready. While a dispatch runs no request is taken. Configuration is on
// the APB port: min_period at 0x0, max_period at 0x4, prescale_ticks at 0x8.
module periodic_task_release_table #(
    parameter int MAX_TASKS = ptrt_pkg::MAX_TASKS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    ptrt_req_if.sink                         i_req,
    ptrt_rsp_if.source                       o_rsp,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ptrt_pkg::APB_AW-1:0] paddr,
    input  wire logic [ptrt_pkg::APB_DW-1:0] pwdata,
    output logic      [ptrt_pkg::APB_DW-1:0] prdata,
    output logic                             pready
);
    import ptrt_pkg::*;

    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    logic [CFG_W-1:0] r_min_per;
    logic [CFG_W-1:0] r_max_per;
    logic [CFG_W-1:0] r_prescale;

    t_fsm             r_state, n_state;
    logic [CW-1:0]    r_used, n_used;
    logic [CFG_W-1:0] r_sub, n_sub;
    logic [IW-1:0]    r_k, n_k;
    logic             r_any, n_any;

    logic             r_ov, n_ov;
    logic [STS_W-1:0] r_sts, n_sts;
    logic             r_dv, n_dv;
    logic [ID_W-1:0]  r_id, n_id;
    logic [TC_W-1:0]  r_tc, n_tc;
    logic             r_last, n_last;

    t_entry   w_entry [MAX_TASKS];
    t_cell_op w_op    [MAX_TASKS];
    t_entry   w_load;

    logic             w_out_free;
    logic             w_accept;
    logic             w_load_out;
    logic             w_elig;
    logic             w_more;
    logic [CFG_W:0]   w_sub_inc;
    logic [STATE_W-1:0] w_init;

    // configuration
    logic [1:0] w_reg_idx;
    assign w_reg_idx = paddr[3:2];
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_per  <= MIN_PERIOD_RST;
            r_max_per  <= MAX_PERIOD_RST;
            r_prescale <= PRESCALE_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (w_reg_idx)
                REG_MIN_PERIOD: r_min_per  <= pwdata[CFG_W-1:0];
                REG_MAX_PERIOD: r_max_per  <= pwdata[CFG_W-1:0];
                REG_PRESCALE:   r_prescale <= pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_MIN_PERIOD: prdata = APB_DW'(r_min_per);
            REG_MAX_PERIOD: prdata = APB_DW'(r_max_per);
            REG_PRESCALE:   prdata = APB_DW'(r_prescale);
            default:        prdata = '0;
        endcase
    end

    // cell ring
    assign w_init = (i_req.initial_state == ST_INVALID) ? ST_BLOCKED : i_req.initial_state;
    assign w_load = '{id: i_req.task_id, period: i_req.period, count: CNT_W'(1), state: w_init};

    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        ptrt_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op[g]),
            .i_load  (w_load),
            .i_next  (w_entry[(g + 1) % MAX_TASKS]),
            .o_entry (w_entry[g])
        );
    end

    assign w_out_free    = !r_ov || o_rsp.ready;
    assign i_req.ready   = (r_state == S_IDLE) && w_out_free;
    assign w_accept      = i_req.valid && i_req.ready;
    assign w_sub_inc     = {1'b0, r_sub} + (CFG_W + 1)'(1);
    assign w_elig        = (CW'(r_k) < r_used) && (w_entry[0].state == ST_READY);

    always_comb begin
        w_more = 1'b0;
        for (int p = 1; p < MAX_TASKS; p++) begin
            if (((int'(r_k) + p) < int'(r_used)) && (w_entry[p].state == ST_READY)) begin
                w_more = 1'b1;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_used     = r_used;
        n_sub      = r_sub;
        n_k        = r_k;
        n_any      = r_any;
        n_sts      = r_sts;
        n_dv       = r_dv;
        n_id       = r_id;
        n_last     = r_last;
        w_load_out = 1'b0;
        for (int i = 0; i < MAX_TASKS; i++) begin
            w_op[i] = C_HOLD;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_sts  = STS_OK;
                    n_dv   = 1'b0;
                    n_id   = '0;
                    n_last = 1'b1;
                    case (t_func'(i_req.func))
                        F_CREATE: begin
                            w_load_out = 1'b1;
                            if (i_req.period > r_max_per || i_req.period < r_min_per) begin
                                n_sts = STS_BAD_PER;
                            end else if (int'(r_used) >= MAX_TASKS) begin
                                n_sts = STS_FULL;
                            end else begin
                                for (int i = 0; i < MAX_TASKS; i++) begin
                                    if (CW'(i) == r_used) begin
                                        w_op[i] = C_LOAD;
                                    end
                                end
                                n_used = r_used + CW'(1);
                            end
                        end
                        F_DELETE: begin
                            w_load_out = 1'b1;
                            if (int'(i_req.slot_index) < int'(r_used)) begin
                                for (int i = 0; i < MAX_TASKS - 1; i++) begin
                                    if (i >= int'(i_req.slot_index)) begin
                                        w_op[i] = C_SHIFT;
                                    end
                                end
                                n_used = r_used - CW'(1);
                            end else begin
                                n_sts = STS_NO_SLOT;
                            end
                        end
                        F_TICK: begin
                            w_load_out = 1'b1;
                            if (w_sub_inc >= {1'b0, r_prescale}) begin
                                n_sub = '0;
                                for (int i = 0; i < MAX_TASKS; i++) begin
                                    w_op[i] = C_TICK;
                                end
                            end else begin
                                n_sub = w_sub_inc[CFG_W-1:0];
                            end
                        end
                        F_DISPATCH: begin
                            n_state = S_DISP;
                            n_k     = '0;
                            n_any   = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DISP: begin
                if (w_elig) begin
                    if (w_out_free) begin
                        w_load_out = 1'b1;
                        n_sts  = STS_OK;
                        n_dv   = 1'b1;
                        n_id   = w_entry[0].id;
                        n_last = !w_more;
                        n_any  = 1'b1;
                        for (int i = 0; i < MAX_TASKS; i++) begin
                            w_op[i] = C_SHIFT;
                        end
                        w_op[MAX_TASKS-1] = C_SHIFT_BLOCK;
                        n_k = r_k + IW'(1);
                        if (r_k == IW'(MAX_TASKS - 1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end else if (r_k != IW'(MAX_TASKS - 1)) begin
                    for (int i = 0; i < MAX_TASKS; i++) begin
                        w_op[i] = C_SHIFT;
                    end
                    n_k = r_k + IW'(1);
                end else if (r_any || w_out_free) begin
                    // no ready task found at all: one empty beat
                    if (!r_any) begin
                        w_load_out = 1'b1;
                        n_sts  = STS_OK;
                        n_dv   = 1'b0;
                        n_id   = '0;
                        n_last = 1'b1;
                    end
                    for (int i = 0; i < MAX_TASKS; i++) begin
                        w_op[i] = C_SHIFT;
                    end
                    n_k     = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_tc = w_load_out ? TC_W'(n_used) : r_tc;
        if (w_load_out) begin
            n_ov = 1'b1;
        end else if (o_rsp.ready) begin
            n_ov = 1'b0;
        end else begin
            n_ov = r_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_sub   <= '0;
            r_k     <= '0;
            r_any   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_sub   <= n_sub;
            r_k     <= n_k;
            r_any   <= n_any;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sts  <= n_sts;
        r_dv   <= n_dv;
        r_id   <= n_id;
        r_tc   <= n_tc;
        r_last <= n_last;
    end

    assign o_rsp.valid          = r_ov;
    assign o_rsp.status         = r_sts;
    assign o_rsp.dispatch_valid = r_dv;
    assign o_rsp.dispatched_id  = r_id;
    assign o_rsp.task_count     = r_tc;
    assign o_rsp.last           = r_last;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_used) <= MAX_TASKS)
        else $error("table fill above capacity");

    a_disp_blocks_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DISP) |-> !i_req.ready)
        else $error("request taken during dispatch walk");

    a_disp_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.func == F_DISPATCH) |=> (r_state == S_DISP))
        else $error("dispatch did not start walk");

    a_disp_keeps_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DISP) |=> (r_used == $past(r_used)))
        else $error("table fill changed during dispatch");

endmodule
`default_nettype wire
